>>> hdl/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection block.
// No dependencies; every other file uses this package.
`default_nettype none
package rti_pkg;

    localparam int FIELD_W     = 63;
    localparam int DIST_W      = 32;
    localparam int CFG_W       = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUOT_BITS   = 31;

    localparam logic [CFG_W-1:0]  DET_EPS_RESET = 32'd16;
    localparam logic [DIST_W-1:0] DIST_SAT_POS  = 32'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] DIST_SAT_NEG  = 32'h8000_0000;

    typedef enum logic [1:0] {
        RSN_HIT      = 2'd0,
        RSN_PARALLEL = 2'd1,
        RSN_U_RANGE  = 2'd2,
        RSN_V_RANGE  = 2'd3
    } t_reason;

    typedef struct packed {
        logic    hit;
        t_reason reason;
        logic    neg;
    } t_cls;

endpackage
`default_nettype wire

>>> hdl/rti_if.sv
// Valid/ready channel interfaces for the ray/triangle block.
// Depends on rti_pkg for field widths.
`default_nettype none
interface rti_in_if;
    logic                        valid;
    logic                        ready;
    logic [rti_pkg::FIELD_W-1:0] ray_origin;
    logic [rti_pkg::FIELD_W-1:0] ray_direction;
    logic [rti_pkg::FIELD_W-1:0] vertex_zero;
    logic [rti_pkg::FIELD_W-1:0] vertex_one;
    logic [rti_pkg::FIELD_W-1:0] vertex_two;

    modport source (output valid, ray_origin, ray_direction, vertex_zero, vertex_one,
                    vertex_two, input ready);
    modport sink   (input valid, ray_origin, ray_direction, vertex_zero, vertex_one,
                    vertex_two, output ready);
endinterface

interface rti_out_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [1:0]                        miss_reason;
    logic signed [rti_pkg::DIST_W-1:0] distance;

    modport source (output valid, hit, miss_reason, distance, input ready);
    modport sink   (input valid, hit, miss_reason, distance, output ready);
endinterface
`default_nettype wire

>>> hdl/rti_front.sv
// Front pipeline: edges, cross products, dot products and classification.
// Depends on rti_pkg and rti_in_if; feeds rti_queue.
`default_nettype none
module rti_front #(
    parameter int COORD_WIDTH = 21,
    parameter int FRAC_BITS   = 12,
    localparam int EW  = COORD_WIDTH + 1,
    localparam int PW  = 2 * EW,
    localparam int XW  = PW + 1 - FRAC_BITS,
    localparam int PDW = EW + XW,
    localparam int DW  = PDW + 2
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire [rti_pkg::CFG_W-1:0]   i_det_eps,
    rti_in_if.sink                     i_in,
    output logic                       o_valid,
    input  wire                        i_ready,
    output rti_pkg::t_cls              o_cls,
    output logic [DW-1:0]              o_adet,
    output logic [DW-1:0]              o_n
);
    import rti_pkg::*;

    localparam int DX   = DW + 2;
    localparam int CMPW = (DW > CFG_W) ? DW : CFG_W;

    logic w_adv;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    logic signed [COORD_WIDTH-1:0] w_org [3], w_dir [3], w_p0 [3], w_p1 [3], w_p2 [3];
    logic signed [EW-1:0] n1_e1 [3], n1_e2 [3], n1_tv [3], n1_dir [3];
    logic signed [EW-1:0] r1_e1 [3], r1_e2 [3], r1_tv [3], r1_dir [3];
    logic signed [EW-1:0] r2_e1 [3], r2_e2 [3], r2_tv [3], r2_dir [3];
    logic signed [EW-1:0] r3_e1 [3], r3_e2 [3], r3_tv [3], r3_dir [3];
    logic signed [PW-1:0] n2_pa [3], n2_pb [3], n2_qa [3], n2_qb [3];
    logic signed [PW-1:0] r2_pa [3], r2_pb [3], r2_qa [3], r2_qb [3];
    logic signed [PW:0]   w_pd [3], w_qd [3];
    logic signed [XW-1:0] r3_pv [3], r3_qv [3];
    logic signed [PDW-1:0] n4_d [3], n4_u [3], n4_v [3], n4_t [3];
    logic signed [PDW-1:0] r4_d [3], r4_u [3], r4_v [3], r4_t [3];
    logic signed [DW-1:0] r5_det, r5_unum, r5_vnum, r5_tnum;

    logic          w_neg_det, w_par, w_u_bad, w_v_bad;
    logic [DW-1:0] w_adet, w_n;
    logic signed [DX-1:0] w_su, w_sv, w_st, w_sdet;
    t_cls          w_cls;

    assign w_adv      = !r_v6 || i_ready;
    assign i_in.ready = w_adv;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_org[k] = signed'(i_in.ray_origin[k*COORD_WIDTH +: COORD_WIDTH]);
            w_dir[k] = signed'(i_in.ray_direction[k*COORD_WIDTH +: COORD_WIDTH]);
            w_p0[k]  = signed'(i_in.vertex_zero[k*COORD_WIDTH +: COORD_WIDTH]);
            w_p1[k]  = signed'(i_in.vertex_one[k*COORD_WIDTH +: COORD_WIDTH]);
            w_p2[k]  = signed'(i_in.vertex_two[k*COORD_WIDTH +: COORD_WIDTH]);
            n1_e1[k]  = EW'(w_p1[k]) - EW'(w_p0[k]);
            n1_e2[k]  = EW'(w_p2[k]) - EW'(w_p0[k]);
            n1_tv[k]  = EW'(w_org[k]) - EW'(w_p0[k]);
            n1_dir[k] = EW'(w_dir[k]);
        end
    end

    // pvec = dir x e2, qvec = tvec x e1
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n2_pa[k] = r1_dir[(k+1)%3] * r1_e2[(k+2)%3];
            n2_pb[k] = r1_dir[(k+2)%3] * r1_e2[(k+1)%3];
            n2_qa[k] = r1_tv[(k+1)%3] * r1_e1[(k+2)%3];
            n2_qb[k] = r1_tv[(k+2)%3] * r1_e1[(k+1)%3];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_pd[k] = (PW+1)'(r2_pa[k]) - (PW+1)'(r2_pb[k]);
            w_qd[k] = (PW+1)'(r2_qa[k]) - (PW+1)'(r2_qb[k]);
            n4_d[k] = r3_e1[k] * r3_pv[k];
            n4_u[k] = r3_tv[k] * r3_pv[k];
            n4_v[k] = r3_dir[k] * r3_qv[k];
            n4_t[k] = r3_e2[k] * r3_qv[k];
        end
    end

    // classify: flip signs so det is positive, then test u and v exactly
    always_comb begin
        w_neg_det = r5_det[DW-1];
        w_adet    = w_neg_det ? DW'(-r5_det) : DW'(r5_det);
        w_par     = (r5_det == '0) || (CMPW'(w_adet) < CMPW'(i_det_eps));
        w_sdet    = signed'(DX'(w_adet));
        w_su      = w_neg_det ? -DX'(r5_unum) : DX'(r5_unum);
        w_sv      = w_neg_det ? -DX'(r5_vnum) : DX'(r5_vnum);
        w_st      = w_neg_det ? -DX'(r5_tnum) : DX'(r5_tnum);
        w_u_bad   = (w_su < 0) || (w_su > w_sdet);
        w_v_bad   = (w_sv < 0) || ((w_su + w_sv) > w_sdet);
        w_n       = (w_st < 0) ? DW'(-w_st) : DW'(w_st);
        w_cls.neg = w_st < 0;
        w_cls.hit = 1'b0;
        priority if (w_par) begin
            w_cls.reason = RSN_PARALLEL;
        end else if (w_u_bad) begin
            w_cls.reason = RSN_U_RANGE;
        end else if (w_v_bad) begin
            w_cls.reason = RSN_V_RANGE;
        end else begin
            w_cls.reason = RSN_HIT;
            w_cls.hit    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r1_e1[k] <= n1_e1[k];
                r1_e2[k] <= n1_e2[k];
                r1_tv[k] <= n1_tv[k];
                r1_dir[k] <= n1_dir[k];
                r2_pa[k] <= n2_pa[k];
                r2_pb[k] <= n2_pb[k];
                r2_qa[k] <= n2_qa[k];
                r2_qb[k] <= n2_qb[k];
                r2_e1[k] <= r1_e1[k];
                r2_e2[k] <= r1_e2[k];
                r2_tv[k] <= r1_tv[k];
                r2_dir[k] <= r1_dir[k];
                // floor shift is the upper bits of the exact difference
                r3_pv[k] <= signed'(w_pd[k][PW:FRAC_BITS]);
                r3_qv[k] <= signed'(w_qd[k][PW:FRAC_BITS]);
                r3_e1[k] <= r2_e1[k];
                r3_e2[k] <= r2_e2[k];
                r3_tv[k] <= r2_tv[k];
                r3_dir[k] <= r2_dir[k];
                r4_d[k] <= n4_d[k];
                r4_u[k] <= n4_u[k];
                r4_v[k] <= n4_v[k];
                r4_t[k] <= n4_t[k];
            end
            r5_det  <= DW'(r4_d[0]) + DW'(r4_d[1]) + DW'(r4_d[2]);
            r5_unum <= DW'(r4_u[0]) + DW'(r4_u[1]) + DW'(r4_u[2]);
            r5_vnum <= DW'(r4_v[0]) + DW'(r4_v[1]) + DW'(r4_v[2]);
            r5_tnum <= DW'(r4_t[0]) + DW'(r4_t[1]) + DW'(r4_t[2]);
            o_cls   <= w_cls;
            o_adet  <= w_adet;
            o_n     <= w_n;
        end
    end

    assign o_valid = r_v6;

endmodule
`default_nettype wire

>>> hdl/rti_queue.sv
// Four-word queue between the front and back pipelines.
// Depends on rti_pkg for depth constants.
`default_nettype none
module rti_queue #(
    parameter int WIDTH = 8
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire [WIDTH-1:0]   i_data,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_empty,
    output logic [WIDTH-1:0]  o_data
);
    import rti_pkg::*;

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

endmodule
`default_nettype wire

>>> hdl/rti_back.sv
// Back pipeline: restoring divide of |t| by |det|, one quotient bit per stage,
// then saturation and the output register. Depends on rti_pkg and rti_out_if.
`default_nettype none
module rti_back #(
    parameter int COORD_WIDTH = 21,
    parameter int FRAC_BITS   = 12,
    localparam int EW  = COORD_WIDTH + 1,
    localparam int XW  = 2 * EW + 1 - FRAC_BITS,
    localparam int DW  = EW + XW + 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  rti_pkg::t_cls    i_cls,
    input  wire [DW-1:0]     i_adet,
    input  wire [DW-1:0]     i_n,
    rti_out_if.source        o_out
);
    import rti_pkg::*;

    localparam int NW = DW + FRAC_BITS;
    localparam int NS = QUOT_BITS + 1;
    localparam logic [DIST_W-1:0] NEG_ONE = DIST_W'(0) - (DIST_W'(1) << FRAC_BITS);

    logic w_adv;
    logic [NW-1:0] w_num;

    logic                 r_v    [NS];
    t_cls                 r_cls  [NS];
    logic                 r_sat  [NS];
    logic [DW-1:0]        r_adet [NS];
    logic [DW-1:0]        r_rem  [NS];
    logic [QUOT_BITS-1:0] r_lo   [NS];
    logic [QUOT_BITS-1:0] r_q    [NS];

    logic [DW:0]          w_t    [NS];
    logic                 w_ge   [NS];
    logic [DW-1:0]        n_rem  [NS];

    logic                 r_out_v;
    logic                 r_out_hit;
    logic [1:0]           r_out_rsn;
    logic [DIST_W-1:0]    r_out_dist;
    logic [DIST_W-1:0]    n_out_dist;

    assign w_adv   = !r_out_v || o_out.ready;
    assign o_ready = w_adv;
    assign w_num   = {i_n, FRAC_BITS'(0)};

    always_comb begin
        w_t[0]   = '0;
        w_ge[0]  = 1'b0;
        n_rem[0] = '0;
        for (int s = 1; s < NS; s++) begin
            w_t[s]   = {r_rem[s-1], r_lo[s-1][QUOT_BITS-1]};
            w_ge[s]  = w_t[s] >= {1'b0, r_adet[s-1]};
            n_rem[s] = w_ge[s] ? DW'(w_t[s] - {1'b0, r_adet[s-1]}) : DW'(w_t[s]);
        end
    end

    always_comb begin
        priority if (!r_cls[NS-1].hit) begin
            n_out_dist = NEG_ONE;
        end else if (r_sat[NS-1]) begin
            n_out_dist = r_cls[NS-1].neg ? DIST_SAT_NEG : DIST_SAT_POS;
        end else if (r_cls[NS-1].neg) begin
            n_out_dist = DIST_W'(0) - {1'b0, r_q[NS-1]};
        end else begin
            n_out_dist = {1'b0, r_q[NS-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_v[s] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < NS; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_out_v <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // upper part of the scaled numerator must stay below det, else t saturates
            r_cls[0]  <= i_cls;
            r_adet[0] <= i_adet;
            r_sat[0]  <= DW'(w_num[NW-1:QUOT_BITS]) >= i_adet;
            r_rem[0]  <= DW'(w_num[NW-1:QUOT_BITS]);
            r_lo[0]   <= w_num[QUOT_BITS-1:0];
            r_q[0]    <= '0;
            for (int s = 1; s < NS; s++) begin
                r_cls[s]  <= r_cls[s-1];
                r_adet[s] <= r_adet[s-1];
                r_sat[s]  <= r_sat[s-1];
                r_rem[s]  <= n_rem[s];
                r_lo[s]   <= {r_lo[s-1][QUOT_BITS-2:0], 1'b0};
                r_q[s]    <= {r_q[s-1][QUOT_BITS-2:0], w_ge[s]};
            end
            r_out_hit  <= r_cls[NS-1].hit;
            r_out_rsn  <= r_cls[NS-1].reason;
            r_out_dist <= n_out_dist;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.hit         = r_out_hit;
    assign o_out.miss_reason = r_out_rsn;
    assign o_out.distance    = signed'(r_out_dist);

endmodule
`default_nettype wire

>>> hdl/ray_triangle_intersect.sv
// Ray/triangle intersection, fixed point. Path: 6 front stages, the queue, then 33
// back stages (divide, one quotient bit per stage). One test per cycle while the
// output is not stalled; back-pressure fills the queue, then stalls the front.
// Reset (synchronous, active low) empties all pipelines and the queue and sets
// det_epsilon to 16.
`default_nettype none
module ray_triangle_intersect #(
    parameter int FRAC_BITS   = 12,
    parameter int COORD_WIDTH = 21
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire [rti_pkg::CFG_W-1:0]  i_cfg_wdata,
    rti_in_if.sink                    i_in,
    rti_out_if.source                 o_out
);
    import rti_pkg::*;

    localparam int EW  = COORD_WIDTH + 1;
    localparam int XW  = 2 * EW + 1 - FRAC_BITS;
    localparam int DW  = EW + XW + 2;
    localparam int QW  = $bits(t_cls) + 2 * DW;
    localparam logic [DIST_W-1:0] NEG_ONE = DIST_W'(0) - (DIST_W'(1) << FRAC_BITS);

    logic [CFG_W-1:0] r_det_eps;

    logic          w_f_valid, w_q_full, w_q_empty, w_b_ready;
    t_cls          w_f_cls, w_b_cls;
    logic [DW-1:0] w_f_adet, w_f_n, w_b_adet, w_b_n;
    logic [QW-1:0] w_q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_eps <= DET_EPS_RESET;
        end else if (i_cfg_we) begin
            r_det_eps <= i_cfg_wdata;
        end
    end

    rti_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_det_eps (r_det_eps),
        .i_in      (i_in),
        .o_valid   (w_f_valid),
        .i_ready   (!w_q_full),
        .o_cls     (w_f_cls),
        .o_adet    (w_f_adet),
        .o_n       (w_f_n)
    );

    rti_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid && !w_q_full),
        .i_data  ({w_f_cls, w_f_adet, w_f_n}),
        .o_full  (w_q_full),
        .i_pop   (w_b_ready && !w_q_empty),
        .o_empty (w_q_empty),
        .o_data  (w_q_out)
    );

    assign {w_b_cls, w_b_adet, w_b_n} = w_q_out;

    rti_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_q_empty),
        .o_ready (w_b_ready),
        .i_cls   (w_b_cls),
        .i_adet  (w_b_adet),
        .i_n     (w_b_n),
        .o_out   (o_out)
    );

    a_hit_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.hit == (o_out.miss_reason == RSN_HIT)))
        else $error("hit flag disagrees with reason code");

    a_reject_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.hit) |-> (o_out.distance == signed'(NEG_ONE)))
        else $error("rejected word without minus-one distance");

    a_front_stall_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> w_q_full)
        else $error("front stalled while queue had room");

endmodule
`default_nettype wire
